>>> sv/tsq_pkg.sv
package tsq_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  // Operation selector carried on the input tuser.
  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_DEQUEUE = 1'b1;

  // Result status carried on the output tuser.
  localparam logic [1:0] STAT_ENQUEUED = 2'd0;
  localparam logic [1:0] STAT_DROPPED  = 2'd1;
  localparam logic [1:0] STAT_DEQUEUED = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  localparam data_t VALUE_EMPTY = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XFER,
    ST_WAIT
  } state_t;

  // One access request to a stack memory.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

endpackage

>>> sv/tsq_stack_ram.sv
module tsq_stack_ram (
  input  logic             clk,
  input  tsq_pkg::ram_req_t req,
  output tsq_pkg::data_t    rdata
);
  import tsq_pkg::*;

  data_t mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

>>> sv/two_stack_queue.sv
// First-in first-out queue built from two stacks of STACK_DEPTH entries.
// Input channel s_*: s_tuser selects the operation (0 enqueue, 1 dequeue)
// and s_tdata carries the value to enqueue. Output channel m_*: one result
// transaction per input transaction, m_tdata the value and m_tuser the
// status (0 enqueued, 1 dropped because the inbound stack is full,
// 2 dequeued, 3 queue empty; the value is all ones when empty).
// An enqueue, or a dequeue of an empty queue, loads the result register
// as the transaction is accepted. A dequeue with elements on the outbound
// stack reads the outbound top, and ST_WAIT registers the value. A dequeue
// that must first refill the outbound stack goes through ST_XFER, moving
// one element per cycle through the read port of the inbound memory, then
// reads the outbound top and registers the value in ST_WAIT.
// Each element is moved once. The block works on one item at a time;
// s_tready is low while a dequeue is being served.
// Reset empties both stacks at once; the memories need no clearing pass.
// The result sits in an output register; while the receiver stalls it
// holds, and the next transaction is taken only once the register frees.
module two_stack_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  tsq_pkg::data_t        s_tdata,   // [31:0] value_in
  input  logic                  s_tuser,   // [0] func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output tsq_pkg::data_t        m_tdata,   // [31:0] value_out
  output logic [1:0]            m_tuser    // [1:0] status
);
  import tsq_pkg::*;

  state_t     state, state_next;
  cnt_t       in_cnt, in_cnt_next;
  cnt_t       out_cnt, out_cnt_next;
  logic       pend, pend_next;
  logic       m_tvalid_next;
  data_t      m_tdata_next;
  logic [1:0] m_tuser_next;

  ram_req_t   in_req, out_req;
  data_t      in_rdata, out_rdata;

  cnt_t       in_top, out_top;
  logic       s_accept;

  tsq_stack_ram u_inbound (
    .clk   (clk),
    .req   (in_req),
    .rdata (in_rdata)
  );

  tsq_stack_ram u_outbound (
    .clk   (clk),
    .req   (out_req),
    .rdata (out_rdata)
  );

  assign in_top   = in_cnt - cnt_t'(1);
  assign out_top  = out_cnt - cnt_t'(1);
  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_cnt   <= '0;
      out_cnt  <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      in_cnt   <= in_cnt_next;
      out_cnt  <= out_cnt_next;
      pend     <= pend_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
  end

  always_comb begin
    state_next    = state;
    in_cnt_next   = in_cnt;
    out_cnt_next  = out_cnt;
    pend_next     = pend;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next  = m_tdata;
    m_tuser_next  = m_tuser;

    in_req        = '0;
    in_req.waddr  = in_cnt[ADDR_W-1:0];
    in_req.wdata  = s_tdata;
    in_req.raddr  = in_top[ADDR_W-1:0];
    out_req       = '0;
    out_req.waddr = out_cnt[ADDR_W-1:0];
    out_req.wdata = in_rdata;
    out_req.raddr = out_top[ADDR_W-1:0];

    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          if (s_tuser == FUNC_ENQUEUE) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = s_tdata;
            if (in_cnt == cnt_t'(STACK_DEPTH)) begin
              m_tuser_next = STAT_DROPPED;
            end else begin
              in_req.we    = 1'b1;
              in_cnt_next  = in_cnt + cnt_t'(1);
              m_tuser_next = STAT_ENQUEUED;
            end
          end else if (in_cnt == '0 && out_cnt == '0) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = VALUE_EMPTY;
            m_tuser_next  = STAT_EMPTY;
          end else if (out_cnt != '0) begin
            out_req.re   = 1'b1;
            out_cnt_next = out_top;
            state_next   = ST_WAIT;
          end else begin
            pend_next  = 1'b0;
            state_next = ST_XFER;
          end
        end
      end
      ST_XFER: begin
        // Read of the inbound top and write of the previous read overlap,
        // so one element moves per cycle.
        if (pend) begin
          out_req.we   = 1'b1;
          out_cnt_next = out_cnt + cnt_t'(1);
        end
        if (in_cnt != '0) begin
          in_req.re   = 1'b1;
          in_cnt_next = in_top;
          pend_next   = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            out_req.re   = 1'b1;
            out_cnt_next = out_top;
            state_next   = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        m_tvalid_next = 1'b1;
        m_tdata_next  = out_rdata;
        m_tuser_next  = STAT_DEQUEUED;
        state_next    = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  logic [CNT_W:0] held_total;
  assign held_total = {1'b0, in_cnt} + {1'b0, out_cnt} + {{CNT_W{1'b0}}, pend};

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    in_cnt <= cnt_t'(STACK_DEPTH) && out_cnt <= cnt_t'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_xfer_start: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tuser == FUNC_DEQUEUE && out_cnt == '0 && in_cnt != '0)
    |=> (state == ST_XFER && out_cnt == '0))
    else $error("refill did not start on an empty outbound stack");

  a_xfer_conserve: assert property (@(posedge clk) disable iff (rst)
    (state == ST_XFER && $past(state) == ST_XFER && !$past(rst))
    |-> held_total == $past(held_total))
    else $error("element lost or duplicated during refill");

  a_wait_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT |-> !m_tvalid)
    else $error("output register busy when dequeued data arrives");

endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = STACK_DEPTH + 8;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int MAX_SEND_GAP   = 40;

  typedef struct packed {
    data_t      value;
    logic [1:0] status;
  } queue_result_t;

  // Directed expectation carried alongside the input transaction.
  typedef struct packed {
    logic       typed;
    data_t      value;
    logic [1:0] status;
  } typed_result_t;

  typedef struct packed {
    logic       op;
    data_t      value;
    logic       rnd_value;
    int         reps;
    logic       typed;
    data_t      exp_value;
    logic [1:0] exp_status;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  data_t         s_tdata = '0;
  logic          s_tuser = FUNC_ENQUEUE;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  data_t         m_tdata;
  logic [1:0]    m_tuser;
  typed_result_t row_expect = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;

  // Mirror of the two stacks.
  data_t inbound_mem [STACK_DEPTH];
  data_t outbound_mem [STACK_DEPTH];
  int    inbound_cnt = 0;
  int    outbound_cnt = 0;

  queue_result_t pending_results [$];

  stim_row_t directed_rows [17] = '{
    '{FUNC_DEQUEUE, 32'h0,         1'b1, 1, 1'b1, VALUE_EMPTY,   STAT_EMPTY},
    '{FUNC_ENQUEUE, 32'h7FFF_FFFF, 1'b0, 1, 1'b1, 32'h7FFF_FFFF, STAT_ENQUEUED},
    '{FUNC_ENQUEUE, 32'h8000_0000, 1'b0, 1, 1'b1, 32'h8000_0000, STAT_ENQUEUED},
    '{FUNC_ENQUEUE, 32'h0,         1'b0, 1, 1'b1, 32'h0,         STAT_ENQUEUED},
    '{FUNC_ENQUEUE, 32'hFFFF_FFFF, 1'b0, 1, 1'b1, 32'hFFFF_FFFF, STAT_ENQUEUED},
    '{FUNC_DEQUEUE, 32'h0,         1'b1, 1, 1'b1, 32'h7FFF_FFFF, STAT_DEQUEUED},
    '{FUNC_ENQUEUE, 32'h1234_5678, 1'b0, 1, 1'b0, 32'h0,         STAT_ENQUEUED},
    '{FUNC_DEQUEUE, 32'h0,         1'b1, 1, 1'b1, 32'h8000_0000, STAT_DEQUEUED},
    '{FUNC_DEQUEUE, 32'h0,         1'b1, 1, 1'b1, 32'h0,         STAT_DEQUEUED},
    '{FUNC_DEQUEUE, 32'h0,         1'b1, 1, 1'b1, 32'hFFFF_FFFF, STAT_DEQUEUED},
    '{FUNC_DEQUEUE, 32'h0,         1'b1, 1, 1'b0, 32'h0,         STAT_DEQUEUED},
    '{FUNC_DEQUEUE, 32'h0,         1'b1, 1, 1'b1, VALUE_EMPTY,   STAT_EMPTY},
    '{FUNC_ENQUEUE, 32'h0,         1'b1, STACK_DEPTH, 1'b0, 32'h0, STAT_ENQUEUED},
    '{FUNC_ENQUEUE, 32'hA5A5_A5A5, 1'b0, 1, 1'b1, 32'hA5A5_A5A5, STAT_DROPPED},
    '{FUNC_DEQUEUE, 32'h0,         1'b1, 1, 1'b0, 32'h0,         STAT_DEQUEUED},
    '{FUNC_ENQUEUE, 32'h0,         1'b1, STACK_DEPTH, 1'b0, 32'h0, STAT_ENQUEUED},
    // Inbound stack full while the outbound stack still has one free entry.
    '{FUNC_ENQUEUE, 32'h5A5A_5A5A, 1'b0, 1, 1'b1, 32'h5A5A_5A5A, STAT_DROPPED}
  };

  two_stack_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic queue_result_t apply_queue_op(logic op, data_t value);
    queue_result_t r;
    if (op == FUNC_ENQUEUE) begin
      r.value = value;
      if (inbound_cnt >= STACK_DEPTH) begin
        r.status = STAT_DROPPED;
      end else begin
        inbound_mem[inbound_cnt] = value;
        inbound_cnt++;
        r.status = STAT_ENQUEUED;
      end
    end else if (inbound_cnt == 0 && outbound_cnt == 0) begin
      r.value  = VALUE_EMPTY;
      r.status = STAT_EMPTY;
    end else begin
      // Refill reverses the inbound stack; both stacks share one depth, so it always fits.
      if (outbound_cnt == 0) begin
        while (inbound_cnt > 0) begin
          inbound_cnt--;
          outbound_mem[outbound_cnt] = inbound_mem[inbound_cnt];
          outbound_cnt++;
        end
      end
      outbound_cnt--;
      r.value  = outbound_mem[outbound_cnt];
      r.status = STAT_DEQUEUED;
    end
    return r;
  endfunction

  function automatic data_t pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic put_item(input logic op, input data_t value, input typed_result_t hint);
    int gap;
    gap = 0;
    while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      repeat (gap) @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tuser    <= op;
    s_tdata    <= value;
    row_expect <= hint;
    do @(posedge clk); while (!s_tready);
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Results are checked before the transaction accepted at the same edge is predicted.
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: value_out %h status %0d", m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          got.value  = m_tdata;
          got.status = m_tuser;
          if (got.value !== want.value) begin
            $error("value_out mismatch: expected %h, actual %h", want.value, got.value);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = apply_queue_op(s_tuser, s_tdata);
        if (row_expect.typed) begin
          want.value  = row_expect.value;
          want.status = row_expect.status;
        end
        pending_results.push_back(want);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int send_pcts [4];
    int stall_pcts [4];
    int sent;
    int burst;
    int enq_pct;
    typed_result_t hint;
    logic op;

    send_pcts  = '{0, 73, 0, 9};
    stall_pcts = '{0, 0, 73, 9};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      hint.typed  = directed_rows[i].typed;
      hint.value  = directed_rows[i].exp_value;
      hint.status = directed_rows[i].exp_status;
      for (int n = 0; n < directed_rows[i].reps; n++) begin
        put_item(directed_rows[i].op,
                 directed_rows[i].rnd_value ? pick_value() : directed_rows[i].value, hint);
      end
    end

    // Random bursts lean toward enqueues or dequeues so occupancy sweeps the whole range.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pcts[phase];
      recv_stall_pct = stall_pcts[phase];
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 64);
        case ($urandom_range(2))
          0: enq_pct = 85;
          1: enq_pct = 50;
          default: enq_pct = 15;
        endcase
        for (int n = 0; n < burst && sent < ITEMS_PER_PHASE; n++) begin
          op = ($urandom_range(99) < enq_pct) ? FUNC_ENQUEUE : FUNC_DEQUEUE;
          put_item(op, pick_value(), '0);
          sent++;
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
